/* src/modulo_hash_bucket_table_macros.svh */
// Assertion macros shared by the table RTL.
// Depends on i_clk and i_rst_n being visible in the including module.
`ifndef MODULO_HASH_BUCKET_TABLE_MACROS_SVH
`define MODULO_HASH_BUCKET_TABLE_MACROS_SVH

// same-cycle implication
`define MHBT_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MHBT_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/mhbt_pkg.sv */
// Types and constants of the modulo hash bucket table.
// No dependencies; used by mhbt_mod, the table top level and the testbench.
`default_nettype none

package mhbt_pkg;

    localparam int KEY_W   = 31;
    localparam int VAL_W   = 32;
    localparam int CFG_W   = 6;
    localparam int STAT_W  = 2;
    localparam int STEP_W  = $clog2(KEY_W);

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd31;

    typedef enum logic [STAT_W-1:0] {
        ST_INSERTED = 2'd0,
        ST_FULL     = 2'd1,
        ST_FOUND    = 2'd2,
        ST_MISSING  = 2'd3
    } t_status;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_FILL_RD,
        S_FILL_WT,
        S_INSERT,
        S_SCAN,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

/* src/mhbt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mhbt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                      i_wr_data,
    input  wire logic                                  i_rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

/* src/mhbt_mod.sv */
// Bit-serial remainder unit: key modulo a 6-bit modulus, one key bit per cycle.
// Depends on mhbt_pkg.
`default_nettype none

module mhbt_mod (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [mhbt_pkg::KEY_W-1:0] i_key,
    input  wire logic [mhbt_pkg::CFG_W-1:0] i_modulus,
    output logic                            o_done,
    output logic      [mhbt_pkg::CFG_W-1:0] o_rem
);

    import mhbt_pkg::*;

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [CFG_W-1:0]  r_rem, n_rem;
    logic [CFG_W:0]    w_trial;

    always_comb begin
        w_trial = {r_rem, r_key[KEY_W-1]};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_key   = r_key;
        n_rem   = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_key  = i_key;
            n_rem  = '0;
        end else if (r_busy) begin
            if (w_trial >= {1'b0, i_modulus}) begin
                n_rem = CFG_W'(w_trial - {1'b0, i_modulus});
            end else begin
                n_rem = CFG_W'(w_trial);
            end
            n_key = {r_key[KEY_W-2:0], 1'b0};
            n_cnt = r_cnt + STEP_W'(1);
            if (r_cnt == STEP_W'(KEY_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_key <= n_key;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

`default_nettype wire

/* src/modulo_hash_bucket_table.sv */
// Modulo-hashed key/value table with bounded buckets, top level.
// Depends on mhbt_pkg, mhbt_mod, mhbt_ram and the assertion macro header.
//
//  channel  | direction | fields (lowest bit first)
//  s_axis   | in        | tdata: key[30:0], entry_value[62:31]; tuser: command
//  m_axis   | out       | tdata: found_value[31:0]; tuser: status[1:0]
//  cfg      | in        | i_cfg_wr_data: bucket_count
//
// After acceptance an item passes the serial remainder, the fill read, an insert or a
// scan of up to ENTRIES slots, and S_DONE; the input is ready again as the result
// becomes valid. The 31-step serial remainder sets most of the delay.
// After reset the fill counts are cleared, one bucket a cycle; no item is taken
// until every bucket is cleared.
// A result waits in the output register; the next item is taken meanwhile.
`default_nettype none
`include "modulo_hash_bucket_table_macros.svh"

module modulo_hash_bucket_table #(
    parameter int BUCKETS = 32,
    parameter int ENTRIES = 8
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_wr_en,
    input  wire logic [mhbt_pkg::CFG_W-1:0]  i_cfg_wr_data,
    input  wire logic                        s_axis_tvalid,
    output logic                             s_axis_tready,
    input  wire logic [63:0]                 s_axis_tdata,  // key, entry_value
    input  wire logic                        s_axis_tuser,  // command
    output logic                             m_axis_tvalid,
    input  wire logic                        m_axis_tready,
    output logic      [31:0]                 m_axis_tdata,  // found_value
    output logic      [1:0]                  m_axis_tuser   // status
);

    import mhbt_pkg::*;

    localparam int BW    = BUCKETS > 1 ? $clog2(BUCKETS) : 1;
    localparam int SLOTS = BUCKETS * ENTRIES;
    localparam int SAW   = SLOTS > 1 ? $clog2(SLOTS) : 1;
    localparam int FW    = $clog2(ENTRIES + 1);

    t_state            r_state, n_state;
    logic [CFG_W-1:0]  r_bucket_count;
    logic [CFG_W-1:0]  w_modulus;
    t_cmd              r_cmd, n_cmd;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [VAL_W-1:0]  r_val, n_val;
    logic [BW-1:0]     r_bucket, n_bucket;
    logic [BW-1:0]     r_clr, n_clr;
    logic [SAW-1:0]    r_base, n_base;
    logic [FW-1:0]     r_fill, n_fill;
    logic [FW-1:0]     r_slot, n_slot;
    logic              r_pend, n_pend;
    t_status           r_res_status, n_res_status;
    logic [VAL_W-1:0]  r_res_value, n_res_value;
    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [VAL_W-1:0]  r_out_value, n_out_value;

    logic              w_accept;
    logic              w_mod_done;
    logic [CFG_W-1:0]  w_rem;
    logic              w_fill_we, w_fill_re;
    logic [BW-1:0]     w_fill_waddr;
    logic [FW-1:0]     w_fill_wdata, w_fill_rdata;
    logic              w_slot_we, w_slot_re;
    logic [SAW-1:0]    w_slot_waddr, w_slot_raddr;
    logic [KEY_W+VAL_W-1:0] w_slot_wdata, w_slot_rdata;
    logic              w_hit;

    assign w_accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (r_bucket_count == '0) begin
            w_modulus = CFG_W'(1);
        end else if (int'(r_bucket_count) > BUCKETS) begin
            w_modulus = CFG_W'(BUCKETS);
        end else begin
            w_modulus = r_bucket_count;
        end
    end

    mhbt_mod u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_key     (s_axis_tdata[KEY_W-1:0]),
        .i_modulus (w_modulus),
        .o_done    (w_mod_done),
        .o_rem     (w_rem)
    );

    mhbt_ram #(.WIDTH(FW), .DEPTH(BUCKETS)) u_fill_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_fill_we),
        .i_wr_addr (w_fill_waddr),
        .i_wr_data (w_fill_wdata),
        .i_rd_en   (w_fill_re),
        .i_rd_addr (r_bucket),
        .o_rd_data (w_fill_rdata)
    );

    mhbt_ram #(.WIDTH(KEY_W + VAL_W), .DEPTH(SLOTS)) u_slot_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_slot_we),
        .i_wr_addr (w_slot_waddr),
        .i_wr_data (w_slot_wdata),
        .i_rd_en   (w_slot_re),
        .i_rd_addr (w_slot_raddr),
        .o_rd_data (w_slot_rdata)
    );

    assign w_hit = r_pend && (w_slot_rdata[KEY_W-1:0] == r_key);

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_val        = r_val;
        n_bucket     = r_bucket;
        n_clr        = r_clr;
        n_base       = r_base;
        n_fill       = r_fill;
        n_slot       = r_slot;
        n_pend       = r_pend;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;
        w_fill_we    = 1'b0;
        w_fill_re    = 1'b0;
        w_fill_waddr = r_bucket;
        w_fill_wdata = r_fill + FW'(1);
        w_slot_we    = 1'b0;
        w_slot_re    = 1'b0;
        w_slot_waddr = r_base + SAW'(r_fill);
        w_slot_raddr = r_base + SAW'(r_slot);
        w_slot_wdata = {r_val, r_key};

        unique case (r_state)
            S_CLEAR: begin
                w_fill_we    = 1'b1;
                w_fill_waddr = r_clr;
                w_fill_wdata = '0;
                n_clr        = r_clr + BW'(1);
                if (r_clr == BW'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_cmd   = t_cmd'(s_axis_tuser);
                    n_key   = s_axis_tdata[KEY_W-1:0];
                    n_val   = s_axis_tdata[KEY_W+VAL_W-1:KEY_W];
                    n_state = S_MOD;
                end
            end
            S_MOD: begin
                if (w_mod_done) begin
                    n_bucket = BW'(w_rem);
                    n_state  = S_FILL_RD;
                end
            end
            S_FILL_RD: begin
                w_fill_re = 1'b1;
                n_base    = SAW'(r_bucket) * SAW'(ENTRIES);
                n_state   = S_FILL_WT;
            end
            S_FILL_WT: begin
                n_fill = w_fill_rdata;
                n_slot = '0;
                n_pend = 1'b0;
                if (r_cmd == CMD_INSERT) begin
                    n_state = S_INSERT;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_INSERT: begin
                n_res_value = '0;
                if (r_fill == FW'(ENTRIES)) begin
                    n_res_status = ST_FULL;
                end else begin
                    w_slot_we    = 1'b1;
                    w_fill_we    = 1'b1;
                    n_res_status = ST_INSERTED;
                end
                n_state = S_DONE;
            end
            S_SCAN: begin
                if (w_hit) begin
                    n_res_status = ST_FOUND;
                    n_res_value  = w_slot_rdata[KEY_W+VAL_W-1:KEY_W];
                    n_state      = S_DONE;
                end else if (r_slot == r_fill) begin
                    n_res_status = ST_MISSING;
                    n_res_value  = '0;
                    n_state      = S_DONE;
                end else begin
                    w_slot_re = 1'b1;
                    n_slot    = r_slot + FW'(1);
                    n_pend    = 1'b1;
                end
            end
            S_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_CLEAR;
            r_clr          <= '0;
            r_out_valid    <= 1'b0;
            r_bucket_count <= CFG_RESET;
            r_pend         <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
            if (i_cfg_wr_en) begin
                r_bucket_count <= i_cfg_wr_data;
            end
        end
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_val        <= n_val;
        r_bucket     <= n_bucket;
        r_base       <= n_base;
        r_fill       <= n_fill;
        r_slot       <= n_slot;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_value;
    assign m_axis_tuser  = r_out_status;

    `MHBT_ASSERT_IMP(a_value_zero_unless_found,
        m_axis_tvalid && (m_axis_tuser != ST_FOUND), m_axis_tdata == '0,
        "found_value nonzero without a match")
    `MHBT_ASSERT_IMP(a_fill_bounded, w_fill_we, w_fill_wdata <= FW'(ENTRIES),
        "bucket fill written beyond capacity")
    `MHBT_ASSERT_NXT(a_busy_after_accept, w_accept, !s_axis_tready,
        "input ready right after an accepted item")
    `MHBT_ASSERT_IMP(a_scan_in_range, r_state == S_SCAN, r_slot <= r_fill,
        "scan ran past the bucket fill")

endmodule

`default_nettype wire

/* tb/testbench.sv */
// Self-checking testbench for modulo_hash_bucket_table: directed rows, then random phases.
// Depends on mhbt_pkg and the table RTL; a local predictor mirrors buckets and pairs.
`default_nettype none

module testbench;
    import mhbt_pkg::*;

    localparam int BUCKETS     = 32;
    localparam int ENTRIES     = 8;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_MAX    = 64;

    typedef struct packed {
        t_status     status;
        logic [31:0] value;
    } t_lookup;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        t_cmd        cmd;
        logic [30:0] key;
        logic [31:0] val;
        logic        typed;
        t_status     exp_status;
        logic [31:0] exp_value;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [5:0]  i_cfg_wr_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;  // key[30:0], entry_value[62:31], zero[63]
    logic        s_axis_tuser = 1'b0;  // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;  // found_value[31:0]
    logic [1:0]  m_axis_tuser;  // status[1:0]

    modulo_hash_bucket_table #(
        .BUCKETS(BUCKETS),
        .ENTRIES(ENTRIES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_wr_data(i_cfg_wr_data),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #20_000_000;
        $display("testbench NOT OK");
        $finish;
    end

    // predictor state
    logic [5:0]  bucket_sel = CFG_RESET;
    int          fill_cnt [BUCKETS];
    logic [30:0] slot_key [BUCKETS*ENTRIES];
    logic [31:0] slot_val [BUCKETS*ENTRIES];

    t_lookup     pending_results [$];
    logic [30:0] key_pool [$];
    int          mismatches = 0;
    int          snd_idle_pct = 0;
    int          rcv_stall_pct = 0;
    bit          rcv_hold = 1'b0;
    bit          pressure_go = 1'b0;

    int snd_pct_by_phase [PHASES] = '{0, 69, 0, 37, 0, 69};
    int rcv_pct_by_phase [PHASES] = '{0, 0, 69, 37, 0, 0};

    t_row directed_rows [27] = '{
        '{ROW_ITEM, CMD_SEARCH, 31'h0000_0000, 32'h0000_0000, 1'b1, ST_MISSING,  32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, ST_MISSING,  32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h0000_0000, 32'h8000_0000, 1'b1, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h7FFF_FFFF, 32'h0000_0000, 1'b1, ST_FOUND,
          32'h7FFF_FFFF},
        '{ROW_ITEM, CMD_SEARCH, 31'h0000_0000, 32'hFFFF_FFFF, 1'b1, ST_FOUND,
          32'h8000_0000},
        '{ROW_ITEM, CMD_INSERT, 31'h0000_0000, 32'h0000_0001, 1'b1, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h0000_0000, 32'h0000_0000, 1'b1, ST_FOUND,
          32'h8000_0000},
        '{ROW_ITEM, CMD_SEARCH, 31'h0000_001F, 32'h0000_0000, 1'b0, ST_MISSING,  32'h0},
        '{ROW_CFG,  CMD_INSERT, 31'h0,         32'd0,         1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h7FFF_FFFF, 32'h0000_0000, 1'b0, ST_MISSING,  32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h1234_5678, 32'hCAFE_F00D, 1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h0000_0005, 32'h0000_0055, 1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h0000_0006, 32'hFFFF_FFFE, 1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h0000_0007, 32'h0000_0007, 1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h5555_5555, 32'hAAAA_AAAA, 1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h2AAA_AAAA, 32'h5555_5555, 1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h0000_0009, 32'h0000_0009, 1'b1, ST_FULL,     32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h2AAA_AAAA, 32'h0000_0000, 1'b0, ST_MISSING,  32'h0},
        '{ROW_CFG,  CMD_INSERT, 31'h0,         32'd63,        1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_INSERT, 31'h0000_003F, 32'hDEAD_BEEF, 1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h0000_003F, 32'h0000_0000, 1'b0, ST_MISSING,  32'h0},
        '{ROW_CFG,  CMD_INSERT, 31'h0,         32'd32,        1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h0000_005F, 32'h0000_0000, 1'b0, ST_MISSING,  32'h0},
        '{ROW_CFG,  CMD_INSERT, 31'h0,         32'd1,         1'b0, ST_INSERTED, 32'h0},
        '{ROW_ITEM, CMD_SEARCH, 31'h0000_0005, 32'h1111_1111, 1'b0, ST_MISSING,  32'h0},
        '{ROW_CFG,  CMD_INSERT, 31'h0,         32'd31,        1'b0, ST_INSERTED, 32'h0}
    };

    function automatic t_lookup table_apply(input t_cmd cmd, input logic [30:0] key,
                                            input logic [31:0] val);
        int unsigned modulus;
        int unsigned bucket;
        int unsigned base;
        int          fill;
        int          i;
        t_lookup     res;
        modulus = bucket_sel;
        if (modulus == 0) modulus = 1;
        if (modulus > BUCKETS) modulus = BUCKETS;
        bucket = int'({1'b0, key}) % modulus;
        base = bucket * ENTRIES;
        fill = fill_cnt[bucket];
        res.value = '0;
        if (cmd == CMD_INSERT) begin
            if (fill >= ENTRIES) begin
                res.status = ST_FULL;
            end else begin
                slot_key[base + fill] = key;
                slot_val[base + fill] = val;
                fill_cnt[bucket] = fill + 1;
                res.status = ST_INSERTED;
            end
        end else begin
            res.status = ST_MISSING;
            for (i = 0; i < fill; i++) begin
                if (slot_key[base + i] == key) begin
                    res.status = ST_FOUND;
                    res.value = slot_val[base + i];
                    break;
                end
            end
        end
        return res;
    endfunction

    task automatic offer_item(input t_cmd cmd, input logic [30:0] key,
                              input logic [31:0] val, input bit typed,
                              input t_lookup typed_res);
        t_lookup predicted;
        if (snd_idle_pct != 0 && $urandom_range(0, 99) < snd_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {1'b0, val, key};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = table_apply(cmd, key, val);
        pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
        if (cmd == CMD_INSERT) begin
            key_pool.insert(key_pool.size(), key);
            if (key_pool.size() > POOL_MAX) void'(key_pool.pop_front());
        end
    endtask

    task automatic write_bucket_count(input logic [5:0] count);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= count;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        bucket_sel = count;
    endtask

    // receiver: random stalls plus one long hold-off
    always @(posedge i_clk) begin
        m_axis_tready <= !rcv_hold && ($urandom_range(0, 99) >= rcv_stall_pct);
    end

    initial begin : pressure
        int n;
        wait (pressure_go);
        @(posedge i_clk);
        rcv_hold <= 1'b1;
        for (n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
        rcv_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        t_lookup exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                if (mismatches < 10)
                    $display("unexpected result: status %0d value %h",
                             m_axis_tuser, m_axis_tdata);
                mismatches++;
            end else begin
                exp_res = pending_results.pop_front();
                if (m_axis_tuser !== exp_res.status || m_axis_tdata !== exp_res.value) begin
                    if (mismatches < 10)
                        $display("mismatch: status exp %0d got %0d, value exp %h got %h",
                                 exp_res.status, m_axis_tuser, exp_res.value, m_axis_tdata);
                    mismatches++;
                end
            end
        end
    end

    initial begin : stimulus
        int      phase;
        int      n;
        int      i;
        t_cmd    cmd;
        logic [30:0] key;
        logic [5:0]  count;
        t_lookup typed_res;
        foreach (fill_cnt[b]) fill_cnt[b] = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < 27; i++) begin
            if (directed_rows[i].kind == ROW_CFG) begin
                write_bucket_count(directed_rows[i].val[5:0]);
            end else begin
                typed_res.status = directed_rows[i].exp_status;
                typed_res.value  = directed_rows[i].exp_value;
                offer_item(directed_rows[i].cmd, directed_rows[i].key,
                           directed_rows[i].val, directed_rows[i].typed, typed_res);
            end
        end

        typed_res = '0;
        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: count = 6'd3;
                1: count = 6'd32;
                2: count = 6'($urandom_range(1, 63));
                3: count = 6'd63;
                4: count = 6'd0;
                default: count = 6'($urandom_range(2, 30));
            endcase
            write_bucket_count(count);
            snd_idle_pct  = snd_pct_by_phase[phase];
            rcv_stall_pct = rcv_pct_by_phase[phase];
            if (phase == 4) pressure_go = 1'b1;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                cmd = ($urandom_range(0, 99) < 40) ? CMD_INSERT : CMD_SEARCH;
                if (cmd == CMD_SEARCH && key_pool.size() != 0 && $urandom_range(0, 99) < 60)
                    key = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else if ($urandom_range(0, 99) < 70)
                    key = 31'($urandom_range(0, 255));
                else
                    key = 31'($urandom);
                offer_item(cmd, key, $urandom, 1'b0, typed_res);
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

`default_nettype wire

/* files.f */
+incdir+src
src/mhbt_pkg.sv
src/mhbt_ram.sv
src/mhbt_mod.sv
src/modulo_hash_bucket_table.sv
tb/testbench.sv
